/* design/dollar_quote_nested_comment_lexer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dollar-quote / nested comment lexer
// Shared property wrappers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef DOLLAR_QUOTE_NESTED_COMMENT_LEXER_UNIT_ASSERT_SVH
`define DOLLAR_QUOTE_NESTED_COMMENT_LEXER_UNIT_ASSERT_SVH

// same-cycle implication
`define DQNC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dqnc assertion failed");

// next-cycle implication
`define DQNC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dqnc assertion failed");

`endif

/* design/dqnc_pkg.sv */
// ---------------------------------------------------------------------------
// dqnc_pkg
// Types and constants shared by the dollar-quote / nested comment lexer.
// ---------------------------------------------------------------------------
package dqnc_pkg;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;

   // result status codes
   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_DOLLAR   = 3'd1;
   localparam logic [2:0] ST_COMMENT  = 3'd2;
   localparam logic [2:0] ST_NONE     = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_TAG     = 3'd1,
      PH_BODY    = 3'd2,
      PH_MATCH   = 3'd3,
      PH_COMMENT = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      SUB_NORMAL = 2'd0,
      SUB_SLASH  = 2'd1,
      SUB_STAR   = 2'd2
   } sub_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       want_dollar;
      logic       want_comment;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       skipped;
   } rsp_type;

endpackage

/* design/dqnc_scan.sv */
// ---------------------------------------------------------------------------
// dqnc_scan
// Per-character scanner: phase machine, tag memory and comment depth counter.
// ---------------------------------------------------------------------------
module dqnc_scan #(
   parameter int TAG_MAX     = 128,
   parameter int DEPTH_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             acc,
   input  dqnc_pkg::req_type req,
   output dqnc_pkg::rsp_type res
);
   import dqnc_pkg::*;

   localparam int LW = $clog2(TAG_MAX + 1);
   localparam int AW = (TAG_MAX > 1) ? $clog2(TAG_MAX) : 1;

   phase_type              phase_ff, phase_in;
   sub_type                sub_ff, sub_in;
   logic [LW-1:0]          tag_len_ff, tag_len_in;
   logic [LW-1:0]          match_ff, match_in;
   logic [DEPTH_WIDTH-1:0] depth_ff, depth_in;

   logic [7:0]             tag_mem [TAG_MAX];
   logic [7:0]             rd_data_ff;
   logic                   wr_en;

   // comment step operands and results
   logic [DEPTH_WIDTH-1:0] cm_depth_src, cm_depth;
   sub_type                cm_sub_src, cm_sub;
   logic                   cm_done;
   logic                   is_space;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         sub_ff     <= SUB_NORMAL;
         tag_len_ff <= '0;
         match_ff   <= '0;
         depth_ff   <= DEPTH_WIDTH'(1);
      end else begin
         phase_ff   <= phase_in;
         sub_ff     <= sub_in;
         tag_len_ff <= tag_len_in;
         match_ff   <= match_in;
         depth_ff   <= depth_in;
      end
   end

   // tag memory: written while collecting the tag, read ahead at the next
   // match index. Writes only happen in the tag phase, which never leads
   // straight into a match, so read and write never collide on a used entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[tag_len_ff[AW-1:0]] <= req.ch;
      end
      rd_data_ff <= tag_mem[match_in[AW-1:0]];
   end

   // comment step: a fresh comment starts from depth one, normal sub-state
   always_comb begin
      cm_depth_src = (phase_ff == PH_IDLE) ? DEPTH_WIDTH'(1) : depth_ff;
      cm_sub_src   = (phase_ff == PH_IDLE) ? SUB_NORMAL : sub_ff;
      cm_depth     = cm_depth_src;
      cm_sub       = SUB_NORMAL;
      cm_done      = 1'b0;
      priority if (cm_sub_src == SUB_SLASH && req.ch == CH_STAR) begin
         if (cm_depth_src != {DEPTH_WIDTH{1'b1}}) begin
            cm_depth = cm_depth_src + DEPTH_WIDTH'(1);
         end
      end else if (cm_sub_src == SUB_STAR && req.ch == CH_SLASH) begin
         if (cm_depth_src != '0) begin
            cm_depth = cm_depth_src - DEPTH_WIDTH'(1);
         end
         cm_done = (cm_depth == '0);
      end else if (req.ch == CH_SLASH) begin
         cm_sub = SUB_SLASH;
      end else if (req.ch == CH_STAR) begin
         cm_sub = SUB_STAR;
      end else begin
         cm_sub = SUB_NORMAL;
      end
   end

   assign is_space = (req.ch == CH_SPACE) || (req.ch == CH_TAB) ||
                     (req.ch == CH_LF) || (req.ch == CH_CR);

   // next state and result
   always_comb begin
      phase_in    = phase_ff;
      sub_in      = sub_ff;
      tag_len_in  = tag_len_ff;
      match_in    = match_ff;
      depth_in    = depth_ff;
      wr_en       = 1'b0;
      res.status  = ST_PENDING;
      res.skipped = 1'b0;

      if (acc) begin
         if (req.ch == CH_NUL) begin
            phase_in   = PH_IDLE;
            match_in   = '0;
            depth_in   = DEPTH_WIDTH'(1);
            sub_in     = SUB_NORMAL;
            res.status = ST_NONE;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  priority if (is_space) begin
                     res.skipped = 1'b1;
                  end else if (req.want_dollar && req.ch == CH_DOLLAR) begin
                     tag_len_in = '0;
                     phase_in   = PH_TAG;
                  end else if (req.want_comment) begin
                     if (cm_done) begin
                        phase_in   = PH_IDLE;
                        depth_in   = DEPTH_WIDTH'(1);
                        sub_in     = SUB_NORMAL;
                        match_in   = '0;
                        res.status = ST_COMMENT;
                     end else begin
                        phase_in = PH_COMMENT;
                        depth_in = cm_depth;
                        sub_in   = cm_sub;
                     end
                  end else begin
                     res.status = ST_NONE;
                  end
               end
               PH_TAG: begin
                  priority if (req.ch == CH_DOLLAR) begin
                     phase_in = PH_BODY;
                     match_in = '0;
                  end else if (tag_len_ff >= LW'(TAG_MAX)) begin
                     phase_in   = PH_IDLE;
                     match_in   = '0;
                     depth_in   = DEPTH_WIDTH'(1);
                     sub_in     = SUB_NORMAL;
                     res.status = ST_OVERFLOW;
                  end else begin
                     wr_en      = 1'b1;
                     tag_len_in = tag_len_ff + LW'(1);
                  end
               end
               PH_BODY, PH_MATCH: begin
                  priority if (phase_ff == PH_MATCH && match_ff < tag_len_ff &&
                               req.ch == rd_data_ff) begin
                     match_in = match_ff + LW'(1);
                  end else if (phase_ff == PH_MATCH && match_ff >= tag_len_ff &&
                               req.ch == CH_DOLLAR) begin
                     phase_in   = PH_IDLE;
                     match_in   = '0;
                     depth_in   = DEPTH_WIDTH'(1);
                     sub_in     = SUB_NORMAL;
                     res.status = ST_DOLLAR;
                  end else begin
                     // mismatch: the character may open a new closing attempt
                     match_in = '0;
                     phase_in = (req.ch == CH_DOLLAR) ? PH_MATCH : PH_BODY;
                  end
               end
               PH_COMMENT: begin
                  if (cm_done) begin
                     phase_in   = PH_IDLE;
                     depth_in   = DEPTH_WIDTH'(1);
                     sub_in     = SUB_NORMAL;
                     match_in   = '0;
                     res.status = ST_COMMENT;
                  end else begin
                     depth_in = cm_depth;
                     sub_in   = cm_sub;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  match_in = '0;
                  depth_in = DEPTH_WIDTH'(1);
                  sub_in   = SUB_NORMAL;
               end
            endcase
         end
      end
   end

endmodule

/* design/dqnc_rsp_buf.sv */
// ---------------------------------------------------------------------------
// dqnc_rsp_buf
// Two-entry result buffer: output register plus skid register.
// ---------------------------------------------------------------------------
module dqnc_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  dqnc_pkg::rsp_type in_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output dqnc_pkg::rsp_type out_data
);
   import dqnc_pkg::*;

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    take;

   assign take      = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign full      = skid_valid_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (main_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            main_ff <= skid_ff;
         end
      end else if (in_valid) begin
         if (main_valid_ff && !take) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

endmodule

/* design/dollar_quote_nested_comment_lexer_unit.sv */
// ---------------------------------------------------------------------------
// dollar_quote_nested_comment_lexer_unit
// Lexer for dollar-quoted strings and nested block comments, one char each.
// ---------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req_data) carries one lookahead
// character plus the two token-acceptable flags per transaction. Response
// channel (rsp_valid / rsp_stall / rsp_data) returns exactly one status and
// skipped flag per request, in order.
// Throughput: one character per cycle while req_stall is low. The closing-tag
// compare uses one byte read from the tag memory, registered ahead at the next
// match index. Each response is held in the output or the skid register.
// Stall: the response path has an output register and a skid register;
// req_stall goes high only while the skid register holds a response. A
// stalled rsp cycle with a response already waiting parks the next result in
// the skid register, so req stalls from the following cycle until it drains.
// Reset: scanner returns to idle (skipping whitespace), tag length and match
// index to zero, comment depth to one; both buffer entries are emptied. The
// tag memory is not cleared and needs no clearing pass: only entries written
// by the current tag are ever compared.
// ---------------------------------------------------------------------------
module dollar_quote_nested_comment_lexer_unit #(
   parameter int TAG_MAX     = 128,
   parameter int DEPTH_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dqnc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqnc_pkg::rsp_type rsp_data
);
   import dqnc_pkg::*;

   logic    req_acc;
   rsp_type scan_res;

   assign req_acc = req_valid && !req_stall;

   // scanner with tag memory
   dqnc_scan #(
      .TAG_MAX     (TAG_MAX),
      .DEPTH_WIDTH (DEPTH_WIDTH)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .acc   (req_acc),
      .req   (req_data),
      .res   (scan_res)
   );

   // response buffer
   dqnc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_acc),
      .in_data   (scan_res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

/* design/dqnc_checker.sv */
// ---------------------------------------------------------------------------
// dqnc_checker
// Port-level checks on the lexer, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "dollar_quote_nested_comment_lexer_unit_assert.svh"

module dqnc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input dqnc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dqnc_pkg::rsp_type rsp_data
);
   import dqnc_pkg::*;

   logic nul_acc;
   logic rsp_none;

   // accepted end of input, and a no-token response on the port
   assign nul_acc  = req_valid && !req_stall && (req_data.ch == CH_NUL);
   assign rsp_none = rsp_valid && (rsp_data.status == ST_NONE);

   // a stalled response holds
   `DQNC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // back-pressure only while a response is waiting
   `DQNC_ASSERT_NOW(a_stall_needs_rsp, req_stall, rsp_valid)

   // skipped whitespace never completes a token
   `DQNC_ASSERT_NOW(a_skip_pending, rsp_valid && rsp_data.skipped, rsp_data.status == ST_PENDING)

   // end of input yields no-token, checked when no response is waiting
   `DQNC_ASSERT_NEXT(a_nul_none, nul_acc && !rsp_valid, rsp_none)

   // response channel is empty right after reset
   `DQNC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind dollar_quote_nested_comment_lexer_unit dqnc_checker u_dqnc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
